// ===== hw/rtl/ir_pulse_length_tick_encoder_core_defines.svh =====
// Assertion macros shared by the tick encoder RTL.
`ifndef IR_PULSE_LENGTH_TICK_ENCODER_CORE_DEFINES_SVH
`define IR_PULSE_LENGTH_TICK_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IRPTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IRPTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/irpte_pkg.sv =====
package irpte_pkg;

  localparam int unsigned DutyW          = 16;
  localparam int unsigned PctW           = 7;
  localparam int unsigned PercentFull    = 100;
  localparam int unsigned DefBits        = 14;
  localparam int unsigned DefHeaderTicks = 4;

  // Product of max_power and the saturated percentage.
  localparam int unsigned ProdW = DutyW + PctW;

  // Divide by 100 as a multiply by ceil(2^30 / 100) and a shift; exact for
  // every product below 2^30 / 76, which covers 65535 * 100.
  localparam int unsigned RecipShift = 30;
  localparam int unsigned RecipW     = 24;
  localparam logic [RecipW-1:0] RecipMul = 24'd10737419;
  localparam int unsigned QuotW      = ProdW + RecipW;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_HDR,
    SEQ_OFF,
    SEQ_ON1,
    SEQ_ON2,
    SEQ_TAIL
  } seq_state_e;

endpackage

// ===== hw/rtl/irpte_power.sv =====
`include "ir_pulse_length_tick_encoder_core_defines.svh"

module irpte_power #(
  parameter int unsigned Bits = irpte_pkg::DefBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [irpte_pkg::DutyW-1:0]  max_power_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [Bits-1:0]              word_i,
  input  logic [irpte_pkg::PctW-1:0]   pct_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [Bits-1:0]              word_o,
  output logic [irpte_pkg::DutyW-1:0]  pwr_o
);

  logic                          va_q, va_d, vb_q, vb_d;
  logic                          en_a, en_b;
  logic [irpte_pkg::PctW-1:0]    pct_sat;
  logic [irpte_pkg::ProdW-1:0]   prod_d, prod_q;
  logic [Bits-1:0]               word_a_q, word_b_q;
  logic [irpte_pkg::QuotW-1:0]   quot;
  logic [irpte_pkg::DutyW-1:0]   pwr_d, pwr_q;

  // A stage moves when it is empty or when the one after it frees up.
  assign en_b       = !vb_q || out_ready_i;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  assign pct_sat = (pct_i > irpte_pkg::PctW'(irpte_pkg::PercentFull)) ?
                   irpte_pkg::PctW'(irpte_pkg::PercentFull) : pct_i;
  assign prod_d  = irpte_pkg::ProdW'(max_power_i) * irpte_pkg::ProdW'(pct_sat);

  assign quot  = irpte_pkg::QuotW'(prod_q) * irpte_pkg::QuotW'(irpte_pkg::RecipMul);
  assign pwr_d = quot[irpte_pkg::RecipShift +: irpte_pkg::DutyW];

  assign va_d = en_a ? in_valid_i : va_q;
  assign vb_d = en_b ? va_q : vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= va_d;
      vb_q <= vb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      prod_q   <= prod_d;
      word_a_q <= word_i;
    end
    if (en_b) begin
      pwr_q    <= pwr_d;
      word_b_q <= word_a_q;
    end
  end

  assign out_valid_o = vb_q;
  assign word_o      = word_b_q;
  assign pwr_o       = pwr_q;

  `IRPTE_ASSERT_NXT(a_stage_a_kept, clk_i, rst_ni, va_q && !en_b, va_q,
                    "power stage A dropped an item while stalled")
  `IRPTE_ASSERT_NXT(a_stage_b_kept, clk_i, rst_ni, vb_q && !out_ready_i,
                    vb_q && $stable(pwr_q), "power stage B lost its item while stalled")

endmodule

// ===== hw/rtl/irpte_tick_seq.sv =====
`include "ir_pulse_length_tick_encoder_core_defines.svh"

module irpte_tick_seq #(
  parameter int unsigned Bits        = irpte_pkg::DefBits,
  parameter int unsigned HeaderTicks = irpte_pkg::DefHeaderTicks
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [Bits-1:0]              word_i,
  input  logic [irpte_pkg::DutyW-1:0]  pwr_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [irpte_pkg::DutyW-1:0]  out_duty_o,
  output logic                         out_last_o
);

  localparam int unsigned HdrCntW = $clog2(HeaderTicks + 1);
  localparam int unsigned BitCntW = $clog2(Bits + 1);
  localparam logic [HdrCntW-1:0] HdrLastCnt = HdrCntW'(HeaderTicks - 1);
  localparam logic [BitCntW-1:0] BitLastCnt = BitCntW'(Bits - 1);

  irpte_pkg::seq_state_e         state_q, state_d;
  logic [HdrCntW-1:0]            hdr_cnt_q, hdr_cnt_d;
  logic [BitCntW-1:0]            bit_cnt_q, bit_cnt_d;
  logic [Bits-1:0]               word_q, word_d;
  logic [irpte_pkg::DutyW-1:0]   pwr_q, pwr_d;
  logic                          out_free, step, load;
  logic [irpte_pkg::DutyW-1:0]   tick_duty;
  logic                          tick_last;
  logic                          out_valid_q;
  logic [irpte_pkg::DutyW-1:0]   out_duty_q;
  logic                          out_last_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = (state_q != irpte_pkg::SEQ_IDLE) && out_free;
  assign in_ready_o = (state_q == irpte_pkg::SEQ_IDLE) ||
                      ((state_q == irpte_pkg::SEQ_TAIL) && out_free);
  assign load       = in_ready_o && in_valid_i;

  always_comb begin
    logic bit_done;
    bit_done  = 1'b0;
    state_d   = state_q;
    hdr_cnt_d = hdr_cnt_q;
    bit_cnt_d = bit_cnt_q;
    word_d    = word_q;
    pwr_d     = pwr_q;
    if (step) begin
      unique case (state_q)
        irpte_pkg::SEQ_HDR: begin
          if (hdr_cnt_q == HdrLastCnt) begin
            state_d   = irpte_pkg::SEQ_OFF;
            bit_cnt_d = '0;
          end else begin
            hdr_cnt_d = HdrCntW'(hdr_cnt_q + 1'b1);
          end
        end
        irpte_pkg::SEQ_OFF: state_d = irpte_pkg::SEQ_ON1;
        irpte_pkg::SEQ_ON1: begin
          if (word_q[Bits-1]) begin
            state_d = irpte_pkg::SEQ_ON2;
          end else begin
            bit_done = 1'b1;
          end
        end
        irpte_pkg::SEQ_ON2:  bit_done = 1'b1;
        irpte_pkg::SEQ_TAIL: state_d = irpte_pkg::SEQ_IDLE;
        default: ;
      endcase
    end
    if (bit_done) begin
      word_d = word_q << 1;
      if (bit_cnt_q == BitLastCnt) begin
        state_d = irpte_pkg::SEQ_TAIL;
      end else begin
        bit_cnt_d = BitCntW'(bit_cnt_q + 1'b1);
        state_d   = irpte_pkg::SEQ_OFF;
      end
    end
    if (load) begin
      state_d   = irpte_pkg::SEQ_HDR;
      hdr_cnt_d = '0;
      word_d    = word_i;
      pwr_d     = pwr_i;
    end
  end

  always_comb begin
    tick_duty = '0;
    tick_last = 1'b0;
    unique case (state_q) inside
      irpte_pkg::SEQ_HDR, irpte_pkg::SEQ_ON1, irpte_pkg::SEQ_ON2: tick_duty = pwr_q;
      irpte_pkg::SEQ_TAIL: tick_last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irpte_pkg::SEQ_IDLE;
      hdr_cnt_q   <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hdr_cnt_q <= hdr_cnt_d;
      bit_cnt_q <= bit_cnt_d;
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pwr_q  <= pwr_d;
    if (out_free) begin
      out_duty_q <= tick_duty;
      out_last_q <= tick_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_duty_o  = out_duty_q;
  assign out_last_o  = out_last_q;

  `IRPTE_ASSERT_IMP(a_last_is_off, clk_i, rst_ni, out_valid_q && out_last_q,
                    out_duty_q == '0, "final tick of a run carries carrier power")
  `IRPTE_ASSERT_NXT(a_load_starts_hdr, clk_i, rst_ni, load,
                    state_q == irpte_pkg::SEQ_HDR, "new word did not start with header")
  `IRPTE_ASSERT_IMP(a_on2_after_on1, clk_i, rst_ni, state_q == irpte_pkg::SEQ_ON2,
                    $past(state_q) == irpte_pkg::SEQ_ON1 ||
                    $past(state_q) == irpte_pkg::SEQ_ON2,
                    "second on tick not preceded by first on tick")

endmodule

// ===== hw/rtl/ir_pulse_length_tick_encoder_core.sv =====
// IR pulse-width tick encoder. Each input item (a data word and a power
// percentage) becomes a run of carrier duty values, one output item per
// modulation tick: HEADER_TICKS ticks at power, then per data bit (MSB
// first) one off tick, one on tick and a second on tick for a one, then a
// closing off tick flagged with tlast. Power is max_power * percent / 100,
// truncated, with percentages above 100 treated as 100. A word yields
// HEADER_TICKS + 2*BITS + (ones in the word) + 1 ticks at the output, 33
// to 47 with the defaults; the tick sequencer emits one tick per cycle
// while its output register is free, and that is the throughput bound.
// Consecutive words follow back to back when the next word already waits
// in the two-stage power pipeline. The user writes max_power through
// cfg_we_i/cfg_wdata_i only while no run is in flight; the block does
// not enforce this. It resets to 0: runs of full shape with zero duty.
module ir_pulse_length_tick_encoder_core #(
  parameter int unsigned BITS         = irpte_pkg::DefBits,
  parameter int unsigned HEADER_TICKS = irpte_pkg::DefHeaderTicks
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config: max_power
  input  logic                              cfg_we_i,
  input  logic [irpte_pkg::DutyW-1:0]       cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [BITS-1:0] data_word, [BITS+6:BITS] power_percent, zero pad above
  input  logic [((BITS + irpte_pkg::PctW + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // output items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] duty
  output logic [irpte_pkg::DutyW-1:0]       m_axis_tdata,
  output logic                              m_axis_tlast
);

  logic [irpte_pkg::DutyW-1:0] max_power_q;
  logic [BITS-1:0]             in_word;
  logic [irpte_pkg::PctW-1:0]  in_pct;
  logic                        pw_valid, pw_ready;
  logic [BITS-1:0]             pw_word;
  logic [irpte_pkg::DutyW-1:0] pw_pwr;

  // Hold the power register; write only between runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q <= '0;
    end else if (cfg_we_i) begin
      max_power_q <= cfg_wdata_i;
    end
  end

  // Unpack the input item; padding bits are dropped.
  assign in_word = s_axis_tdata[BITS-1:0];
  assign in_pct  = s_axis_tdata[BITS +: irpte_pkg::PctW];

  // Saturate the percentage and scale max_power, two registered stages.
  irpte_power #(
    .Bits(BITS)
  ) u_power (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_power_i(max_power_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .word_i     (in_word),
    .pct_i      (in_pct),
    .out_valid_o(pw_valid),
    .out_ready_i(pw_ready),
    .word_o     (pw_word),
    .pwr_o      (pw_pwr)
  );

  // Walk header, bit and tail ticks; advance one tick per cycle into the
  // output register while it is free, and take the next word on the tail tick or when idle.
  irpte_tick_seq #(
    .Bits       (BITS),
    .HeaderTicks(HEADER_TICKS)
  ) u_tick_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pw_valid),
    .in_ready_o (pw_ready),
    .word_i     (pw_word),
    .pwr_i      (pw_pwr),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_duty_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WordW       = irpte_pkg::DefBits;
  localparam int unsigned PctW        = irpte_pkg::PctW;
  localparam int unsigned DutyW       = irpte_pkg::DutyW;
  localparam int unsigned PercentFull = irpte_pkg::PercentFull;
  localparam int unsigned HdrTicks    = irpte_pkg::DefHeaderTicks;
  localparam int unsigned TdataW    = ((WordW + PctW + 7) / 8) * 8;
  localparam int unsigned MaxGap    = 16;
  // Cycles to wait after the last tick before touching max_power or ending.
  localparam int unsigned SettleCyc = 8;
  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Receiver hold-off that forces the encoder to back up into its input.
  localparam int unsigned LongHold  = 400;
  localparam int unsigned HoldAfter = 1500;
  localparam int unsigned MaxPrints = 40;

  typedef struct {
    logic [WordW-1:0] word;
    logic [PctW-1:0]  pct;
  } word_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             last;
  } tick_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_we_i      = 1'b0;
  logic [DutyW-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DutyW-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  // Words waiting to be offered, and the ticks predicted for accepted words.
  word_item_t pending_words[$];
  tick_t      pending_ticks[$];

  logic [DutyW-1:0] max_power_mdl = '0;

  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned ticks_seen   = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;

  // Handshake flags of the last rising edge, seen by the falling-edge drivers.
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  always #5 clk_i = ~clk_i;

  ir_pulse_length_tick_encoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Prediction: expand one word into its full run of duty ticks.
  // ---------------------------------------------------------------------------
  function automatic void predict_duty_run(logic [WordW-1:0] word, logic [PctW-1:0] pct);
    int unsigned      pct_sat;
    logic [DutyW-1:0] power;
    pct_sat = (pct > PercentFull) ? PercentFull : pct;
    power   = DutyW'((int'(max_power_mdl) * pct_sat) / PercentFull);
    // Header: carrier on at full run power.
    for (int h = 0; h < HdrTicks; h++) pending_ticks.push_back('{power, 1'b0});
    // Data bits, MSB first: off, on, and a second on for a one.
    for (int b = WordW - 1; b >= 0; b--) begin
      pending_ticks.push_back('{'0, 1'b0});
      pending_ticks.push_back('{power, 1'b0});
      if (word[b]) pending_ticks.push_back('{power, 1'b0});
    end
    // Closing off tick carries the end-of-run flag.
    pending_ticks.push_back('{'0, 1'b1});
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < MaxPrints) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_tick(logic [DutyW-1:0] duty, logic last);
    tick_t want;
    ticks_seen++;
    if (pending_ticks.size() == 0) begin
      report_mismatch($sformatf("tick %0d unexpected: duty %0d last %0b",
                                ticks_seen, duty, last));
      return;
    end
    want = pending_ticks.pop_front();
    if (duty !== want.duty)
      report_mismatch($sformatf("tick %0d duty %0d, want %0d", ticks_seen, duty, want.duty));
    if (last !== want.last)
      report_mismatch($sformatf("tick %0d last %0b, want %0b", ticks_seen, last, want.last));
  endtask

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_duty_run(s_axis_tdata[WordW-1:0], s_axis_tdata[WordW+PctW-1:WordW]);
        words_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) check_tick(m_axis_tdata, m_axis_tlast);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued words, idling a random number of cycles after each.
  // ---------------------------------------------------------------------------
  int unsigned send_gap   = 0;
  bit          send_burst = 1'b0;

  always @(negedge clk_i) begin
    word_item_t itm;
    logic       nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (in_fire) begin
      // Drop valid after an accepted item and draw the idle time before the next.
      nxt_valid = 1'b0;
      if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
      send_gap = draw_gap(send_burst);
    end
    if (rst_ni && !nxt_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_words.size() > 0) begin
        itm          = pending_words.pop_front();
        s_axis_tdata <= TdataW'({itm.pct, itm.word});
        nxt_valid    = 1'b1;
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall a random number of cycles after each tick, and once hold
  // off for a long stretch so the encoder stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned recv_gap   = 0;
  int unsigned hold_left  = 0;
  bit          recv_burst = 1'b0;
  bit          held_once  = 1'b0;

  always @(negedge clk_i) begin
    if (out_fire) begin
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      recv_gap = draw_gap(recv_burst);
    end
    if (!held_once && ticks_seen >= HoldAfter) begin
      hold_left = LongHold;
      held_once = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no item moves for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing.
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic [WordW-1:0] word, logic [PctW-1:0] pct);
    pending_words.push_back('{word, pct});
    words_queued++;
  endtask

  task automatic queue_random_words(int unsigned count);
    logic [WordW-1:0] word;
    logic [PctW-1:0]  pct;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = WordW'($urandom_range(0, (1 << WordW) - 1));
      endcase
      // Mostly legal percentages, some above full scale to hit saturation.
      if ($urandom_range(0, 7) == 0) pct = PctW'($urandom_range(PercentFull + 1, 127));
      else                            pct = PctW'($urandom_range(0, PercentFull));
      queue_word(word, pct);
    end
  endtask

  // Hold until every offered word is taken and every tick has come out.
  task automatic wait_run_done();
    while (words_taken != words_queued || pending_ticks.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // Write max_power; only called with the encoder idle.
  task automatic write_max_power(logic [DutyW-1:0] val);
    @(negedge clk_i);
    cfg_wdata_i <= val;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    max_power_mdl = val;
  endtask

  task automatic run_random_phase(logic [DutyW-1:0] power, int unsigned count);
    wait_run_done();
    write_max_power(power);
    queue_random_words(count / 2);
    // Pause the sender mid-phase until the encoder drains completely.
    wait_run_done();
    queue_random_words(count - count / 2);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of max_power is zero: runs keep their shape, duty stays 0.
    queue_word('1, 7'd100);
    queue_word('0, 7'd0);

    // Full-scale power: word extremes, alternating bits, MSB only, saturation.
    wait_run_done();
    write_max_power('1);
    queue_word('0, 7'd100);
    queue_word('1, 7'd100);
    queue_word(14'h2AAA, 7'd50);
    queue_word(14'h1555, 7'd99);
    queue_word(14'h2000, 7'd1);
    queue_word(14'h0001, 7'd101);
    queue_word('1, 7'd127);
    queue_word(14'h2001, 7'd0);
    queue_word(14'h1FFE, 7'd64);

    // Smallest nonzero power: truncation drops everything below full percent.
    wait_run_done();
    write_max_power(16'd1);
    queue_word('1, 7'd100);
    queue_word('0, 7'd99);
    queue_word(14'h2AAA, 7'd127);

    // Odd power value to check truncation of the divide.
    wait_run_done();
    write_max_power(16'd333);
    queue_word(14'h155A, 7'd33);
    queue_word(14'h3C3C, 7'd101);
    queue_word('0, 7'd1);

    // Random traffic across several power settings, extremes included.
    run_random_phase(DutyW'($urandom_range(1, 65534)), 52);
    run_random_phase('1, 52);
    run_random_phase('0, 52);
    run_random_phase(16'h8000, 52);
    run_random_phase(DutyW'($urandom_range(0, 65535)), 52);

    wait_run_done();
    repeat (SettleCyc) @(negedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
